>>> hw/rtl/mpctb_pkg.sv
// Shared types and constants for the countdown timer bank.
// Function codes, controller states and the controller/datapath interface structs.
// No dependencies.
package mpctb_pkg;

	// Stream widths: the input beat is 41 bits of fields padded to 48 bits.
	// The output beat is 17 bits of fields padded to 24 bits.
	localparam int IN_W  = 48;
	localparam int OUT_W = 24;

	// Layout of one timer entry: bit 15 is the enable bit, bits 14..0 the count.
	localparam int ENTRY_W = 16;
	localparam int COUNT_W = 15;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

	// The duration in microseconds is turned into 5 ms ticks.
	// dur / 5000 == (dur >> 3) / 625, and the division by 625 is a multiplication
	// by ceil(2^40 / 625) followed by a right shift of 40 bits. This is exact for
	// every 29-bit dividend.
	localparam int DIV_IN_W   = 29;
	localparam int RECIP_W    = 31;
	localparam int PROD_W     = DIV_IN_W + RECIP_W;
	localparam int RECIP_SHIFT = 40;
	localparam logic [RECIP_W-1:0] TICK_RECIP = 31'd1759218605;
	localparam int QUOT_W     = PROD_W - RECIP_SHIFT;

	typedef enum logic [2:0] {
		FN_CLEAR  = 3'd0,
		FN_ARM    = 3'd1,
		FN_DISARM = 3'd2,
		FN_TICK   = 3'd3,
		FN_QUERY  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DISPATCH,
		ST_SWEEP,
		ST_ARM,
		ST_LOOKUP,
		ST_RESULT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch_in;
		logic cnt_clr;
		logic cnt_inc;
		logic init_wr;
		logic sweep;
		logic arm_wr;
		logic disarm_wr;
		logic lookup;
		logic result_ld;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic port_ok;
		logic tmr_ok;
		logic is_clear;
		logic is_tick;
		logic is_arm;
		logic is_disarm;
		logic cnt_last;
		logic init_last;
		logic out_free;
	} status_t;

endpackage

>>> hw/rtl/mpctb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the timer store.
module mpctb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/mpctb_ctrl.sv
// Controller state machine of the timer bank.
// Depends on mpctb_pkg for the state type and the command and status structs.
module mpctb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               in_ready,
	input  mpctb_pkg::status_t status,
	output mpctb_pkg::cmd_t    cmd
);

	mpctb_pkg::state_t state_q;
	mpctb_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpctb_pkg::ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mpctb_pkg::ST_INIT: begin
				if (status.init_last) begin
					state_nxt = mpctb_pkg::ST_IDLE;
				end
			end
			mpctb_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = mpctb_pkg::ST_DISPATCH;
				end
			end
			mpctb_pkg::ST_DISPATCH: begin
				if (!status.port_ok) begin
					state_nxt = mpctb_pkg::ST_LOOKUP;
				end else if (status.is_clear || status.is_tick) begin
					state_nxt = mpctb_pkg::ST_SWEEP;
				end else if (status.is_arm && status.tmr_ok) begin
					state_nxt = mpctb_pkg::ST_ARM;
				end else begin
					state_nxt = mpctb_pkg::ST_LOOKUP;
				end
			end
			mpctb_pkg::ST_SWEEP: begin
				if (status.cnt_last) begin
					state_nxt = mpctb_pkg::ST_LOOKUP;
				end
			end
			mpctb_pkg::ST_ARM: begin
				state_nxt = mpctb_pkg::ST_LOOKUP;
			end
			mpctb_pkg::ST_LOOKUP: begin
				state_nxt = mpctb_pkg::ST_RESULT;
			end
			mpctb_pkg::ST_RESULT: begin
				if (status.out_free) begin
					state_nxt = mpctb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = mpctb_pkg::ST_INIT;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			mpctb_pkg::ST_INIT: begin
				cmd.init_wr = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.cnt_clr = status.init_last;
			end
			mpctb_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = s_tvalid;
				cmd.cnt_clr  = s_tvalid;
			end
			mpctb_pkg::ST_DISPATCH: begin
				// A disarm is a single write; everything else moves on to its own state.
				cmd.disarm_wr = status.port_ok && status.tmr_ok && status.is_disarm;
			end
			mpctb_pkg::ST_SWEEP: begin
				cmd.sweep   = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			mpctb_pkg::ST_ARM: begin
				cmd.arm_wr = 1'b1;
			end
			mpctb_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			mpctb_pkg::ST_RESULT: begin
				cmd.result_ld = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> hw/rtl/mpctb_dp.sv
// Datapath of the timer bank: input registers, sweep counter, tick conversion,
// timer store and output register. Depends on mpctb_pkg and mpctb_ram.
module mpctb_dp #(
	parameter int PORTS           = 2,
	parameter int TIMERS_PER_PORT = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mpctb_pkg::cmd_t    cmd,
	output mpctb_pkg::status_t status,
	input  logic [2:0]         func,
	input  logic               port_index,
	input  logic [4:0]         timer_index,
	input  logic [31:0]        duration_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               is_disabled,
	output logic               is_expired,
	output logic [14:0]        ticks_left
);

	localparam int DEPTH = PORTS * TIMERS_PER_PORT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [2:0]  func_q;
	logic        port_q;
	logic [4:0]  tmr_q;
	logic [31:0] dur_q;
	logic [CNT_W-1:0] cnt_q;
	logic [mpctb_pkg::PROD_W-1:0] prod_q;
	logic        out_valid_q;
	logic        is_disabled_q;
	logic        is_expired_q;
	logic [14:0] ticks_left_q;

	logic [AW-1:0] base;
	logic [AW-1:0] idx;
	logic [AW-1:0] sweep_addr;
	logic [mpctb_pkg::QUOT_W-1:0] quot;
	logic [mpctb_pkg::COUNT_W-1:0] arm_ticks;
	logic [mpctb_pkg::ENTRY_W-1:0] tick_val;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [mpctb_pkg::ENTRY_W-1:0] ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [mpctb_pkg::ENTRY_W-1:0] ram_rdata;

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			func_q <= func;
			port_q <= port_index;
			tmr_q  <= timer_index;
			dur_q  <= duration_us;
		end
		prod_q <= dur_q[31:3] * mpctb_pkg::TICK_RECIP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign status.port_ok   = 32'(port_q) < PORTS;
	assign status.tmr_ok    = 32'(tmr_q) < TIMERS_PER_PORT;
	assign status.is_clear  = func_q == mpctb_pkg::FN_CLEAR;
	assign status.is_tick   = func_q == mpctb_pkg::FN_TICK;
	assign status.is_arm    = func_q == mpctb_pkg::FN_ARM;
	assign status.is_disarm = func_q == mpctb_pkg::FN_DISARM;
	assign status.cnt_last  = cnt_q == CNT_W'(TIMERS_PER_PORT);
	assign status.init_last = cnt_q == CNT_W'(DEPTH - 1);
	assign status.out_free  = !out_valid_q || out_ready;

	assign base       = port_q ? AW'(TIMERS_PER_PORT) : '0;
	assign idx        = base + AW'(tmr_q);
	assign sweep_addr = base + AW'(cnt_q);

	assign quot      = prod_q[mpctb_pkg::PROD_W-1:mpctb_pkg::RECIP_SHIFT];
	assign arm_ticks = (quot > mpctb_pkg::QUOT_W'(mpctb_pkg::COUNT_MAX)) ?
		mpctb_pkg::COUNT_MAX : quot[mpctb_pkg::COUNT_W-1:0];

	// An armed timer with time left counts down; expired and idle entries stay.
	assign tick_val = (ram_rdata[15] && (ram_rdata[14:0] != '0)) ?
		ram_rdata - 16'd1 : ram_rdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = idx;
		if (cmd.init_wr) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(cnt_q);
		end else if (cmd.sweep) begin
			if (status.is_clear) begin
				ram_we    = !status.cnt_last;
				ram_waddr = sweep_addr;
			end else begin
				// The read of entry n overlaps the write-back of entry n-1.
				ram_re    = !status.cnt_last;
				ram_raddr = sweep_addr;
				ram_we    = cnt_q != '0;
				ram_waddr = sweep_addr - AW'(1);
				ram_wdata = tick_val;
			end
		end else if (cmd.arm_wr) begin
			ram_we    = 1'b1;
			ram_wdata = {1'b1, arm_ticks};
		end else if (cmd.disarm_wr) begin
			ram_we = 1'b1;
		end else if (cmd.lookup) begin
			ram_re = 1'b1;
		end
	end

	mpctb_ram #(
		.WIDTH(mpctb_pkg::ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_ld) begin
			if (status.port_ok && status.tmr_ok) begin
				is_disabled_q <= !ram_rdata[15];
				is_expired_q  <= ram_rdata[15] && (ram_rdata[14:0] == '0);
				ticks_left_q  <= ram_rdata[14:0];
			end else begin
				is_disabled_q <= 1'b1;
				is_expired_q  <= 1'b0;
				ticks_left_q  <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign is_disabled = is_disabled_q;
	assign is_expired  = is_expired_q;
	assign ticks_left  = ticks_left_q;

endmodule

>>> hw/rtl/multi_port_countdown_timer_bank_unit.sv
// Countdown timer bank, top level. One item is in work at a time, so the block takes no new beat
// before the last one's result is loaded; the next beat can be taken in the cycle after the result
// loads. A clear or tick walks the port's timers through the single-write, single-read RAM.
// After arst_n releases, a clearing pass zeroes all PORTS * TIMERS_PER_PORT entries of the store.
module multi_port_countdown_timer_bank_unit #(
	parameter int PORTS           = 2,
	parameter int TIMERS_PER_PORT = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input stream. s_tdata from bit 0 up: func[2:0], port_index[3],
	// timer_index[8:4], duration_us[40:9], zero padding[47:41].
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [mpctb_pkg::IN_W-1:0] s_tdata,
	// Result stream. m_tdata from bit 0 up: is_disabled[0], is_expired[1],
	// ticks_left[16:2], zero padding[23:17].
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mpctb_pkg::OUT_W-1:0] m_tdata
);

	mpctb_pkg::cmd_t    cmd;
	mpctb_pkg::status_t status;

	logic        is_disabled;
	logic        is_expired;
	logic [14:0] ticks_left;

	// The controller sequences each item: dispatch on the function code, then a
	// sweep over the port, an arm write, a disarm write or none of these, then a read of the
	// addressed timer that becomes the result beat.
	mpctb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.in_ready(s_tready),
		.status  (status),
		.cmd     (cmd)
	);

	// The datapath holds the timer store and the output register, so a finished
	// result can wait on m_tready while the next beat is accepted.
	mpctb_dp #(
		.PORTS          (PORTS),
		.TIMERS_PER_PORT(TIMERS_PER_PORT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.func       (s_tdata[2:0]),
		.port_index (s_tdata[3]),
		.timer_index(s_tdata[8:4]),
		.duration_us(s_tdata[40:9]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.is_disabled(is_disabled),
		.is_expired (is_expired),
		.ticks_left (ticks_left)
	);

	assign m_tdata = {7'd0, ticks_left, is_expired, is_disabled};

endmodule

>>> hw/rtl/mpctb_checker.sv
// Port-level checks for the countdown timer bank, bound to the top level.
// Depends on mpctb_pkg for the stream widths.
module mpctb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [mpctb_pkg::OUT_W-1:0] m_tdata
);

	// Only one item is in work: the input is closed in the cycle after a beat is accepted.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// A result appears only after the cycle in which the block was busy.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result beat without an item in work");

	// A disabled timer never reports expiry or a nonzero count.
	a_disabled_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[1] && (m_tdata[16:2] == 15'd0))
		else $error("disabled timer with state");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

endmodule

bind multi_port_countdown_timer_bank_unit mpctb_checker u_mpctb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the countdown timer bank: a clocked driver and monitor
// on the two stream ports, with a shadow copy of the timer store to predict each result.
// Depends on mpctb_pkg and multi_port_countdown_timer_bank_unit.
module tb_top;

	localparam int BANK_PORTS  = 2;
	localparam int BANK_TIMERS = 32;
	localparam int TICK_US     = 5000;
	// Function codes above FN_QUERY are unused; the block treats them as a query.
	localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FN_SPARE_MID   = 3'd6;
	localparam logic [2:0] FN_SPARE_LAST  = 3'd7;
	localparam int ITEMS_PER_PHASE = 255;
	localparam int SETTLE_CYCLES   = 64;

	typedef struct packed {
		logic        hold_for_drain;
		logic [31:0] duration_us;
		logic [4:0]  timer_index;
		logic        port_index;
		logic [2:0]  func;
	} timer_cmd_t;

	typedef struct packed {
		logic        disabled;
		logic        expired;
		logic [14:0] ticks_left;
	} timer_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [mpctb_pkg::IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [mpctb_pkg::OUT_W-1:0] m_tdata;

	timer_cmd_t    pending_cmds[$];
	timer_report_t expected_reports[$];
	timer_cmd_t    cmd_on_bus;
	logic [15:0]   timer_shadow [BANK_PORTS*BANK_TIMERS];
	int            cmds_queued = 0;
	int            fault_count = 0;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;

	multi_port_countdown_timer_bank_unit #(
		.PORTS(BANK_PORTS),
		.TIMERS_PER_PORT(BANK_TIMERS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	initial begin
		for (int i = 0; i < BANK_PORTS*BANK_TIMERS; i++) begin
			timer_shadow[i] = '0;
		end
	end

	// Applies one command to the shadow store and returns the report for the
	// addressed timer as it stands afterwards.
	function automatic timer_report_t step_timer_shadow(input timer_cmd_t c);
		timer_report_t rep;
		logic          port_in;
		logic          tmr_in;
		int            base;
		logic [31:0]   tick_cnt;
		logic [15:0]   entry;
		port_in = (int'(c.port_index) < BANK_PORTS);
		tmr_in  = (int'(c.timer_index) < BANK_TIMERS);
		base    = int'(c.port_index) * BANK_TIMERS;
		if (port_in) begin
			case (c.func)
				mpctb_pkg::FN_CLEAR: begin
					for (int i = 0; i < BANK_TIMERS; i++) begin
						timer_shadow[base + i] = '0;
					end
				end
				mpctb_pkg::FN_TICK: begin
					// Only armed timers with ticks left count down; expired ones hold.
					for (int i = 0; i < BANK_TIMERS; i++) begin
						entry = timer_shadow[base + i];
						if (entry[15] && entry[14:0] != '0) begin
							timer_shadow[base + i] = entry - 16'd1;
						end
					end
				end
				mpctb_pkg::FN_ARM: begin
					if (tmr_in) begin
						tick_cnt = c.duration_us / TICK_US;
						if (tick_cnt > {17'd0, mpctb_pkg::COUNT_MAX}) begin
							tick_cnt = {17'd0, mpctb_pkg::COUNT_MAX};
						end
						timer_shadow[base + int'(c.timer_index)] = {1'b1, tick_cnt[14:0]};
					end
				end
				mpctb_pkg::FN_DISARM: begin
					if (tmr_in) begin
						timer_shadow[base + int'(c.timer_index)] = '0;
					end
				end
				default: begin
				end
			endcase
		end
		if (port_in && tmr_in) begin
			entry = timer_shadow[base + int'(c.timer_index)];
			rep.disabled   = ~entry[15];
			rep.expired    = entry[15] && (entry[14:0] == '0);
			rep.ticks_left = entry[14:0];
		end else begin
			rep.disabled   = 1'b1;
			rep.expired    = 1'b0;
			rep.ticks_left = '0;
		end
		return rep;
	endfunction

	// Driver. A held beat stays put until accepted; a command flagged hold_for_drain
	// is not presented until every outstanding result has come back.
	always @(posedge clk) begin
		timer_cmd_t nxt;
		logic       launch;
		launch = 1'b0;
		nxt = '0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_reports.push_back(step_timer_shadow(cmd_on_bus));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					if (!pending_cmds[0].hold_for_drain || expected_reports.size() == 0) begin
						launch = 1'b1;
					end
				end
				if (launch) begin
					nxt = pending_cmds.pop_front();
					cmd_on_bus = nxt;
					s_tdata <= {7'd0, nxt.duration_us, nxt.timer_index, nxt.port_index,
						nxt.func};
				end
				s_tvalid <= launch;
			end
		end
	end

	task automatic report_mismatch(input string field, input int exp_v, input int got_v);
		fault_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
	endtask

	// Monitor. Every result beat is checked against the oldest prediction.
	always @(posedge clk) begin
		timer_report_t exp_rep;
		timer_report_t got_rep;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_rep = {m_tdata[0], m_tdata[1], m_tdata[16:2]};
				if (expected_reports.size() == 0) begin
					fault_count++;
					$display("%0t: result beat with none expected, expected nothing, got %h",
						$time, m_tdata);
				end else begin
					exp_rep = expected_reports.pop_front();
					if (got_rep.disabled !== exp_rep.disabled) begin
						report_mismatch("is_disabled", int'(exp_rep.disabled),
							int'(got_rep.disabled));
					end
					if (got_rep.expired !== exp_rep.expired) begin
						report_mismatch("is_expired", int'(exp_rep.expired),
							int'(got_rep.expired));
					end
					if (got_rep.ticks_left !== exp_rep.ticks_left) begin
						report_mismatch("ticks_left", int'(exp_rep.ticks_left),
							int'(got_rep.ticks_left));
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic add_cmd(input logic [2:0] func, input logic port, input logic [4:0] tmr,
		input logic [31:0] dur, input logic hold);
		timer_cmd_t c;
		c.func = func;
		c.port_index = port;
		c.timer_index = tmr;
		c.duration_us = dur;
		c.hold_for_drain = hold;
		pending_cmds.push_back(c);
		cmds_queued++;
	endtask

	// A duration of a few ticks, with a random remainder below one tick.
	function automatic logic [31:0] short_duration();
		return $urandom_range(0, 9) * TICK_US + $urandom_range(0, TICK_US - 1);
	endfunction

	// Arms a few timers of one port and ticks them down, mostly until they expire,
	// with queries, disarms and ticks of the other port mixed in.
	task automatic queue_countdown_run();
		logic       p;
		logic [4:0] tmrs [4];
		int         n_arm;
		int         n_step;
		p = 1'($urandom_range(0, 1));
		n_arm = $urandom_range(1, 4);
		for (int k = 0; k < n_arm; k++) begin
			tmrs[k] = 5'($urandom_range(0, BANK_TIMERS - 1));
			add_cmd(mpctb_pkg::FN_ARM, p, tmrs[k], short_duration(), 1'b0);
		end
		n_step = $urandom_range(1, 12);
		for (int k = 0; k < n_step; k++) begin
			case ($urandom_range(0, 9))
				0: add_cmd(mpctb_pkg::FN_QUERY, p, tmrs[$urandom_range(0, n_arm - 1)],
					$urandom, 1'b0);
				1: add_cmd(mpctb_pkg::FN_DISARM, p, tmrs[$urandom_range(0, n_arm - 1)],
					$urandom, 1'b0);
				2: add_cmd(mpctb_pkg::FN_TICK, ~p, 5'($urandom_range(0, BANK_TIMERS - 1)),
					$urandom, 1'b0);
				default: add_cmd(mpctb_pkg::FN_TICK, p, tmrs[$urandom_range(0, n_arm - 1)],
					$urandom, 1'b0);
			endcase
		end
		if ($urandom_range(0, 3) == 0) begin
			add_cmd(mpctb_pkg::FN_CLEAR, p, tmrs[0], $urandom, 1'b0);
		end
	endtask

	// One unconstrained command, including the unused codes and durations near saturation.
	task automatic queue_noise();
		logic [31:0] dur;
		case ($urandom_range(0, 2))
			0: dur = $urandom;
			1: dur = short_duration();
			default: dur = $urandom_range(163830000, 163850000);
		endcase
		add_cmd(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
			5'($urandom_range(0, 31)), dur, $urandom_range(0, 49) == 0);
	endtask

	task automatic queue_directed();
		add_cmd(mpctb_pkg::FN_QUERY, 1'b0, 5'd0, 32'd0, 1'b0);
		// Zero duration arms a timer that is expired at once, and a tick leaves it there.
		add_cmd(mpctb_pkg::FN_ARM, 1'b0, 5'd0, 32'd0, 1'b0);
		add_cmd(mpctb_pkg::FN_TICK, 1'b0, 5'd0, 32'hFFFF_FFFF, 1'b0);
		add_cmd(mpctb_pkg::FN_ARM, 1'b0, 5'd31, 32'd4999, 1'b0);
		add_cmd(mpctb_pkg::FN_ARM, 1'b1, 5'd31, 32'd5000, 1'b0);
		add_cmd(mpctb_pkg::FN_TICK, 1'b1, 5'd31, 32'd0, 1'b0);
		add_cmd(mpctb_pkg::FN_TICK, 1'b1, 5'd31, 32'd0, 1'b1);
		// Durations right at and beyond the largest count.
		add_cmd(mpctb_pkg::FN_ARM, 1'b1, 5'd0, 32'd163839999, 1'b0);
		add_cmd(mpctb_pkg::FN_ARM, 1'b1, 5'd1, 32'd163840000, 1'b0);
		add_cmd(mpctb_pkg::FN_ARM, 1'b1, 5'd2, 32'hFFFF_FFFF, 1'b0);
		add_cmd(mpctb_pkg::FN_TICK, 1'b1, 5'd1, 32'd0, 1'b0);
		add_cmd(mpctb_pkg::FN_DISARM, 1'b1, 5'd1, 32'd0, 1'b0);
		// A disarmed timer ignores ticks.
		add_cmd(mpctb_pkg::FN_TICK, 1'b1, 5'd1, 32'd0, 1'b0);
		add_cmd(mpctb_pkg::FN_QUERY, 1'b1, 5'd2, 32'd0, 1'b0);
		add_cmd(FN_SPARE_FIRST, 1'b1, 5'd0, 32'hFFFF_FFFF, 1'b0);
		add_cmd(FN_SPARE_MID, 1'b0, 5'd31, 32'd0, 1'b0);
		add_cmd(FN_SPARE_LAST, 1'b1, 5'd2, 32'hFFFF_FFFF, 1'b0);
		add_cmd(mpctb_pkg::FN_CLEAR, 1'b1, 5'd2, 32'd0, 1'b0);
		add_cmd(mpctb_pkg::FN_QUERY, 1'b1, 5'd0, 32'd0, 1'b0);
		add_cmd(mpctb_pkg::FN_ARM, 1'b0, 5'd5, 32'd25000, 1'b0);
		add_cmd(mpctb_pkg::FN_TICK, 1'b0, 5'd0, 32'd0, 1'b0);
		add_cmd(mpctb_pkg::FN_DISARM, 1'b0, 5'd0, 32'd0, 1'b0);
		add_cmd(mpctb_pkg::FN_QUERY, 1'b0, 5'd5, 32'd0, 1'b0);
		add_cmd(mpctb_pkg::FN_CLEAR, 1'b0, 5'd0, 32'hFFFF_FFFF, 1'b0);
	endtask

	// Stimulus: three phases with different idle patterns on the two sides.
	initial begin
		int target;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 68;
				end
				1: begin
					send_idle_pct = 68;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (phase == 0) begin
				queue_directed();
			end
			target = cmds_queued + ITEMS_PER_PHASE;
			while (cmds_queued < target) begin
				if ($urandom_range(0, 9) < 7) begin
					queue_countdown_run();
				end else begin
					queue_noise();
				end
			end
			while (pending_cmds.size() != 0) begin
				@(posedge clk);
			end
		end
		while (s_tvalid || expected_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/mpctb_pkg.sv
hw/rtl/mpctb_ram.sv
hw/rtl/mpctb_ctrl.sv
hw/rtl/mpctb_dp.sv
hw/rtl/multi_port_countdown_timer_bank_unit.sv
hw/rtl/mpctb_checker.sv
verif/tb_top.sv
